@@ rtl/ray_differential_transfer_top_assert.svh @@
// Assertion macros for the ray differential transfer block.
// Included by the top level; relies on its clock and reset port names.
`ifndef RAY_DIFFERENTIAL_TRANSFER_TOP_ASSERT_SVH
`define RAY_DIFFERENTIAL_TRANSFER_TOP_ASSERT_SVH

// Condition that must hold in the same cycle as its trigger.
`define RDT_ASSERT_NOW(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

// Condition that must hold after its trigger, delayed by dly.
`define RDT_ASSERT_AFTER(label, trig, dly, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> ##dly (cons)) \
      else $error(msg);

`endif

@@ rtl/rdt_pkg.sv @@
// Package for the ray differential transfer block: widths, latencies and
// payload types. No dependencies; used by every module of the block.
package rdt_pkg;

   localparam int COMP_BITS = 21;
   localparam int VEC_W     = 3 * COMP_BITS;
   localparam int T_W       = 31;
   localparam int T_SHIFT   = 16;
   localparam int DT_W      = 32;

   // Internal datapath widths.
   localparam int PT_W   = COMP_BITS + T_W + 1;
   localparam int W_W    = COMP_BITS + T_W + 2;
   localparam int NV_W   = W_W - T_SHIFT;
   localparam int E_W    = COMP_BITS + 1;
   localparam int DEN_W  = E_W + NV_W + 2;
   localparam int NUM_W  = W_W + NV_W + 1;
   localparam int DIFF_W = W_W + DEN_W;

   // Multiplier parameters.
   localparam int LIMB_W   = 32;
   localparam int A_LIMBS  = 3;
   localparam int B_LIMBS  = 2;
   localparam int MUL_A_W  = A_LIMBS * LIMB_W;
   localparam int MUL_B_W  = B_LIMBS * LIMB_W;
   localparam int MUL_P_W  = 128;
   localparam int MUL_LAT  = 4;

   // Divider parameters.
   localparam int DIV_W   = DIFF_W;
   localparam int Q_BITS  = DT_W - 1;
   localparam int DIV_LAT = Q_BITS + 1;

   // Request to result, in clock edges.
   localparam int PIPE_LAT = 2 + MUL_LAT + 1 + MUL_LAT + 2 + DIV_LAT + 1;

   typedef logic signed [COMP_BITS-1:0] comp_type;

   typedef struct packed {
      logic [VEC_W-1:0] ray_origin;
      logic [VEC_W-1:0] ray_direction;
      logic [T_W-1:0]   hit_distance;
      logic [VEC_W-1:0] sphere_center;
      logic [T_W-1:0]   sphere_radius;
      logic [VEC_W-1:0] surface_normal;
      logic [VEC_W-1:0] origin_diff;
      logic [VEC_W-1:0] direction_diff;
   } rdt_req_type;

   typedef struct packed {
      logic signed [DT_W-1:0] distance_diff;
      logic [VEC_W-1:0]       position_diff;
      logic                   degenerate;
   } rdt_rsp_type;

endpackage

@@ rtl/rdt_mul.sv @@
// Pipelined signed multiplier built from 32x32 limb products.
// Depends on rdt_pkg for operand widths; the product output is registered.
module rdt_mul import rdt_pkg::*; (
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] mul_a,
   input  logic signed [MUL_B_W-1:0] mul_b,
   output logic signed [MUL_P_W-1:0] mul_p
);

   logic [MUL_A_W-1:0]  mag_a_ff;
   logic [MUL_B_W-1:0]  mag_b_ff;
   logic                sgn_a_ff, sgn_b_ff, sgn_c_ff;
   logic [2*LIMB_W-1:0] pp_ff [A_LIMBS][B_LIMBS];
   logic [MUL_P_W-1:0]  sum_ff, sum_in;
   logic [MUL_P_W-1:0]  prod_ff;

   // Stage one: split into sign and magnitude.
   always_ff @(posedge clock) begin
      sgn_a_ff <= mul_a[MUL_A_W-1] ^ mul_b[MUL_B_W-1];
      mag_a_ff <= mul_a[MUL_A_W-1] ? MUL_A_W'(-mul_a) : MUL_A_W'(mul_a);
      mag_b_ff <= mul_b[MUL_B_W-1] ? MUL_B_W'(-mul_b) : MUL_B_W'(mul_b);
   end

   // Stage two: limb products.
   always_ff @(posedge clock) begin
      sgn_b_ff <= sgn_a_ff;
      for (int j = 0; j < A_LIMBS; j++) begin
         for (int k = 0; k < B_LIMBS; k++) begin
            pp_ff[j][k] <= mag_a_ff[j*LIMB_W +: LIMB_W] * mag_b_ff[k*LIMB_W +: LIMB_W];
         end
      end
   end

   // Stage three: add the shifted limb products.
   always_comb begin
      sum_in = '0;
      for (int j = 0; j < A_LIMBS; j++) begin
         for (int k = 0; k < B_LIMBS; k++) begin
            sum_in = sum_in + (MUL_P_W'(pp_ff[j][k]) << (LIMB_W * (j + k)));
         end
      end
   end

   always_ff @(posedge clock) begin
      sgn_c_ff <= sgn_b_ff;
      sum_ff   <= sum_in;
   end

   // Stage four: restore the sign.
   always_ff @(posedge clock) begin
      prod_ff <= sgn_c_ff ? -sum_ff : sum_ff;
   end

   assign mul_p = prod_ff;

endmodule

@@ rtl/rdt_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on rdt_pkg. Overflow flags a quotient that does not fit in
// Q_BITS bits.
module rdt_div import rdt_pkg::*; (
   input  logic              clock,
   input  logic [DIV_W-1:0]  div_num,
   input  logic [DIV_W-1:0]  div_den,
   output logic [Q_BITS-1:0] div_quo,
   output logic              div_ovf
);

   logic [DIV_W-1:0]  rem_ff [Q_BITS+1];
   logic [DIV_W-1:0]  den_ff [Q_BITS+1];
   logic [Q_BITS-1:0] quo_ff [Q_BITS+1];
   logic              ovf_ff [Q_BITS+1];

   // Entry stage: capture operands and check the quotient range.
   always_ff @(posedge clock) begin
      rem_ff[0] <= div_num;
      den_ff[0] <= div_den;
      quo_ff[0] <= '0;
      ovf_ff[0] <= {{Q_BITS{1'b0}}, div_num} >= {div_den, {Q_BITS{1'b0}}};
   end

   // One trial subtraction per stage, most significant quotient bit first.
   for (genvar k = 0; k < Q_BITS; k++) begin : g_step
      logic [DIV_W+Q_BITS-1:0] den_sh;
      logic                    fits;

      assign den_sh = {{Q_BITS{1'b0}}, den_ff[k]} << (Q_BITS - 1 - k);
      assign fits   = {{Q_BITS{1'b0}}, rem_ff[k]} >= den_sh;

      always_ff @(posedge clock) begin
         rem_ff[k+1] <= fits ? rem_ff[k] - den_sh[DIV_W-1:0] : rem_ff[k];
         den_ff[k+1] <= den_ff[k];
         quo_ff[k+1] <= quo_ff[k] | (fits ? (Q_BITS'(1) << (Q_BITS - 1 - k)) : '0);
         ovf_ff[k+1] <= ovf_ff[k];
      end
   end

   assign div_quo = quo_ff[Q_BITS];
   assign div_ovf = ovf_ff[Q_BITS];

endmodule

@@ rtl/ray_differential_transfer_top.sv @@
// Top level of the ray differential transfer block.
// Depends on rdt_pkg, rdt_mul, rdt_div and the assertion macro header.
//
// Usage:
// - A request is taken at a rising edge with start high and busy low. busy
//   is always low, so a new ray may be issued in every cycle.
// - Each result appears on rsp_data for exactly one cycle, marked by
//   rsp_valid, once its request has passed all pipeline stages. Results
//   come back in request order. The receiver cannot stall the block.
// - Throughput is one ray per cycle. Latency is set by two chained
//   four-stage 32x32 limb multipliers and the 32-stage divider that yields
//   one quotient bit per stage.
// - transfer_mode is written through csr_valid/csr_data; csr_ready is
//   always high. Write it only while no request is in flight; each request
//   captures the mode on entry.
// - Synchronous reset clears the mode to plane transfer and drops every
//   request in flight; no result is produced for those.
// - A zero divisor, or a zero radius in sphere mode, sets degenerate and
//   zeroes the other result fields.
`include "ray_differential_transfer_top_assert.svh"

module ray_differential_transfer_top import rdt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  rdt_req_type req_data,
   output logic        rsp_valid,
   output rdt_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   // Control registers.
   logic                mode_ff;
   logic [PIPE_LAT-2:0] vld_ff;
   logic                rsp_valid_ff;
   rdt_rsp_type         rsp_data_ff, rsp_data_in;
   logic                accept;

   // Entry stage.
   comp_type              p_c [3], c_c [3], n_c [3], dp_c [3], d_c [3], dd_c [3];
   logic signed [T_W:0]   t_c;
   comp_type              p_s1_ff [3], c_s1_ff [3], n_s1_ff [3];
   comp_type              dp_s1_ff [3], d_s1_ff [3], dd_s1_ff [3];
   logic signed [PT_W-1:0] tdd_s1_ff [3], dtp_s1_ff [3];
   logic                  mode_s1_ff, rz_s1_ff;

   // Vector stage.
   logic signed [W_W-1:0]  m_c [3], w_c [3];
   logic signed [NV_W-1:0] nv_c [3];
   logic signed [E_W-1:0]  e_c [3];
   logic signed [W_W-1:0]  w_s2_ff [3];
   logic signed [NV_W-1:0] nv_s2_ff [3];
   logic signed [E_W-1:0]  e_s2_ff [3];
   logic                   mode_s2_ff, rz_s2_ff;

   // First product bank and its side data.
   logic signed [MUL_P_W-1:0] den_p [3], num_p [3];
   logic signed [W_W-1:0]     w_d1_ff [MUL_LAT][3];
   logic signed [E_W-1:0]     e_d1_ff [MUL_LAT][3];
   logic                      mode_d1_ff [MUL_LAT], rz_d1_ff [MUL_LAT];

   // Dot product stage.
   logic signed [DEN_W-1:0] den_s7_ff;
   logic signed [NUM_W-1:0] num_s7_ff;
   logic signed [W_W-1:0]   w_s7_ff [3];
   logic signed [E_W-1:0]   e_s7_ff [3];
   logic                    mode_s7_ff, rz_s7_ff;

   // Second product bank and its side data.
   logic signed [MUL_P_W-1:0] t1_p [3], t2_p [3];
   logic signed [DEN_W-1:0]   den_d2_ff [MUL_LAT];
   logic signed [NUM_W-1:0]   num_d2_ff [MUL_LAT];
   logic                      mode_d2_ff [MUL_LAT], rz_d2_ff [MUL_LAT];

   // Difference and magnitude stages.
   logic signed [DIFF_W-1:0] diff_ff [3];
   logic signed [DEN_W-1:0]  den_s12_ff;
   logic signed [NUM_W-1:0]  num_s12_ff;
   logic                     mode_s12_ff, degen_s12_ff;
   logic [NUM_W-1:0]         num_mag;
   logic [DEN_W-1:0]         den_mag;
   logic [DIFF_W-1:0]        diff_mag [3];
   logic [DIV_W-1:0]         an_ff, ad_ff, dd_ff;
   logic [DIV_W-1:0]         ap_ff [3];
   logic                     dtneg_ff, degen_s13_ff;
   logic [2:0]               pneg_ff;

   // Divider outputs and side data.
   logic [Q_BITS-1:0] dt_quo;
   logic              dt_ovf;
   logic [Q_BITS-1:0] p_quo [3];
   logic              p_ovf [3];
   logic              dtneg_d3_ff [DIV_LAT], degen_d3_ff [DIV_LAT];
   logic [2:0]        pneg_d3_ff [DIV_LAT];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   // Mode register and request valid chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_data;
         end
         vld_ff       <= {vld_ff[PIPE_LAT-3:0], accept};
         rsp_valid_ff <= vld_ff[PIPE_LAT-2];
      end
   end

   // Unpack the request vectors.
   always_comb begin
      t_c = $signed({1'b0, req_data.hit_distance});
      for (int i = 0; i < 3; i++) begin
         p_c[i]  = req_data.ray_origin[i*COMP_BITS +: COMP_BITS];
         d_c[i]  = req_data.ray_direction[i*COMP_BITS +: COMP_BITS];
         c_c[i]  = req_data.sphere_center[i*COMP_BITS +: COMP_BITS];
         n_c[i]  = req_data.surface_normal[i*COMP_BITS +: COMP_BITS];
         dp_c[i] = req_data.origin_diff[i*COMP_BITS +: COMP_BITS];
         dd_c[i] = req_data.direction_diff[i*COMP_BITS +: COMP_BITS];
      end
   end

   // Entry stage: scale direction and its differential by the hit distance.
   always_ff @(posedge clock) begin
      mode_s1_ff <= mode_ff;
      rz_s1_ff   <= mode_ff & (req_data.sphere_radius == '0);
      for (int i = 0; i < 3; i++) begin
         p_s1_ff[i]   <= p_c[i];
         c_s1_ff[i]   <= c_c[i];
         n_s1_ff[i]   <= n_c[i];
         dp_s1_ff[i]  <= dp_c[i];
         d_s1_ff[i]   <= d_c[i];
         dd_s1_ff[i]  <= dd_c[i];
         tdd_s1_ff[i] <= t_c * dd_c[i];
         dtp_s1_ff[i] <= t_c * d_c[i];
      end
   end

   // Vector stage: offset vector w, plane normal and ray direction per mode.
   // The sphere normal is the hit point minus the centre, rounded half up.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         w_c[i] = (W_W'(dp_s1_ff[i]) <<< T_SHIFT) + W_W'(tdd_s1_ff[i]);
         m_c[i] = (W_W'(p_s1_ff[i]) <<< T_SHIFT) + W_W'(dtp_s1_ff[i])
                - (W_W'(c_s1_ff[i]) <<< T_SHIFT) + (W_W'(1) << (T_SHIFT - 1));
         if (mode_s1_ff) begin
            nv_c[i] = m_c[i][W_W-1:T_SHIFT];
            e_c[i]  = E_W'(d_s1_ff[i]) + E_W'(dd_s1_ff[i]);
         end else begin
            nv_c[i] = NV_W'(n_s1_ff[i]);
            e_c[i]  = E_W'(d_s1_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_s2_ff <= mode_s1_ff;
      rz_s2_ff   <= rz_s1_ff;
      w_s2_ff    <= w_c;
      nv_s2_ff   <= nv_c;
      e_s2_ff    <= e_c;
   end

   // First product bank: terms of both dot products.
   for (genvar i = 0; i < 3; i++) begin : g_dot
      rdt_mul u_den_mul (
         .clock (clock),
         .mul_a (MUL_A_W'(nv_s2_ff[i])),
         .mul_b (MUL_B_W'(e_s2_ff[i])),
         .mul_p (den_p[i])
      );
      rdt_mul u_num_mul (
         .clock (clock),
         .mul_a (MUL_A_W'(w_s2_ff[i])),
         .mul_b (MUL_B_W'(nv_s2_ff[i])),
         .mul_p (num_p[i])
      );
   end

   // Side data alongside the first product bank.
   always_ff @(posedge clock) begin
      w_d1_ff[0]    <= w_s2_ff;
      e_d1_ff[0]    <= e_s2_ff;
      mode_d1_ff[0] <= mode_s2_ff;
      rz_d1_ff[0]   <= rz_s2_ff;
      for (int j = 1; j < MUL_LAT; j++) begin
         w_d1_ff[j]    <= w_d1_ff[j-1];
         e_d1_ff[j]    <= e_d1_ff[j-1];
         mode_d1_ff[j] <= mode_d1_ff[j-1];
         rz_d1_ff[j]   <= rz_d1_ff[j-1];
      end
   end

   // Dot product stage: sum the three terms.
   always_ff @(posedge clock) begin
      den_s7_ff  <= den_p[0][DEN_W-1:0] + den_p[1][DEN_W-1:0] + den_p[2][DEN_W-1:0];
      num_s7_ff  <= num_p[0][NUM_W-1:0] + num_p[1][NUM_W-1:0] + num_p[2][NUM_W-1:0];
      w_s7_ff    <= w_d1_ff[MUL_LAT-1];
      e_s7_ff    <= e_d1_ff[MUL_LAT-1];
      mode_s7_ff <= mode_d1_ff[MUL_LAT-1];
      rz_s7_ff   <= rz_d1_ff[MUL_LAT-1];
   end

   // Second product bank: w*den and num*e for each component.
   for (genvar i = 0; i < 3; i++) begin : g_pos
      rdt_mul u_t1_mul (
         .clock (clock),
         .mul_a (MUL_A_W'(w_s7_ff[i])),
         .mul_b (MUL_B_W'(den_s7_ff)),
         .mul_p (t1_p[i])
      );
      rdt_mul u_t2_mul (
         .clock (clock),
         .mul_a (MUL_A_W'(num_s7_ff)),
         .mul_b (MUL_B_W'(e_s7_ff[i])),
         .mul_p (t2_p[i])
      );
   end

   // Side data alongside the second product bank.
   always_ff @(posedge clock) begin
      den_d2_ff[0]  <= den_s7_ff;
      num_d2_ff[0]  <= num_s7_ff;
      mode_d2_ff[0] <= mode_s7_ff;
      rz_d2_ff[0]   <= rz_s7_ff;
      for (int j = 1; j < MUL_LAT; j++) begin
         den_d2_ff[j]  <= den_d2_ff[j-1];
         num_d2_ff[j]  <= num_d2_ff[j-1];
         mode_d2_ff[j] <= mode_d2_ff[j-1];
         rz_d2_ff[j]   <= rz_d2_ff[j-1];
      end
   end

   // Difference stage: position numerators and the degenerate check.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         diff_ff[i] <= t1_p[i][DIFF_W-1:0] - t2_p[i][DIFF_W-1:0];
      end
      den_s12_ff   <= den_d2_ff[MUL_LAT-1];
      num_s12_ff   <= num_d2_ff[MUL_LAT-1];
      mode_s12_ff  <= mode_d2_ff[MUL_LAT-1];
      degen_s12_ff <= rz_d2_ff[MUL_LAT-1] | (den_d2_ff[MUL_LAT-1] == '0);
   end

   // Magnitude stage: unsigned operands and quotient signs for the dividers.
   // The plane transfer negates the distance quotient.
   always_comb begin
      num_mag = num_s12_ff[NUM_W-1] ? NUM_W'(-num_s12_ff) : NUM_W'(num_s12_ff);
      den_mag = den_s12_ff[DEN_W-1] ? DEN_W'(-den_s12_ff) : DEN_W'(den_s12_ff);
      for (int i = 0; i < 3; i++) begin
         diff_mag[i] = diff_ff[i][DIFF_W-1] ? DIFF_W'(-diff_ff[i]) : DIFF_W'(diff_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      an_ff        <= DIV_W'(num_mag);
      ad_ff        <= DIV_W'(den_mag);
      dd_ff        <= DIV_W'(den_mag) << T_SHIFT;
      dtneg_ff     <= num_s12_ff[NUM_W-1] ^ den_s12_ff[DEN_W-1] ^ ~mode_s12_ff;
      degen_s13_ff <= degen_s12_ff;
      for (int i = 0; i < 3; i++) begin
         ap_ff[i]   <= DIV_W'(diff_mag[i]);
         pneg_ff[i] <= diff_ff[i][DIFF_W-1] ^ den_s12_ff[DEN_W-1];
      end
   end

   // Dividers: distance differential and the three position components.
   rdt_div u_dt_div (
      .clock   (clock),
      .div_num (an_ff),
      .div_den (ad_ff),
      .div_quo (dt_quo),
      .div_ovf (dt_ovf)
   );

   for (genvar i = 0; i < 3; i++) begin : g_pdiv
      rdt_div u_p_div (
         .clock   (clock),
         .div_num (ap_ff[i]),
         .div_den (dd_ff),
         .div_quo (p_quo[i]),
         .div_ovf (p_ovf[i])
      );
   end

   // Side data alongside the dividers.
   always_ff @(posedge clock) begin
      dtneg_d3_ff[0] <= dtneg_ff;
      pneg_d3_ff[0]  <= pneg_ff;
      degen_d3_ff[0] <= degen_s13_ff;
      for (int j = 1; j < DIV_LAT; j++) begin
         dtneg_d3_ff[j] <= dtneg_d3_ff[j-1];
         pneg_d3_ff[j]  <= pneg_d3_ff[j-1];
         degen_d3_ff[j] <= degen_d3_ff[j-1];
      end
   end

   // Result stage: apply signs, saturate, and zero degenerate results.
   always_comb begin
      rsp_data_in = '0;
      rsp_data_in.degenerate = degen_d3_ff[DIV_LAT-1];
      if (!degen_d3_ff[DIV_LAT-1]) begin
         if (dt_ovf) begin
            rsp_data_in.distance_diff = dtneg_d3_ff[DIV_LAT-1] ?
               {1'b1, {(DT_W-1){1'b0}}} : {1'b0, {(DT_W-1){1'b1}}};
         end else if (dtneg_d3_ff[DIV_LAT-1]) begin
            rsp_data_in.distance_diff = -{1'b0, dt_quo};
         end else begin
            rsp_data_in.distance_diff = {1'b0, dt_quo};
         end
         for (int i = 0; i < 3; i++) begin
            if (p_ovf[i] || (p_quo[i][Q_BITS-1:COMP_BITS-1] != '0)) begin
               rsp_data_in.position_diff[i*COMP_BITS +: COMP_BITS] =
                  pneg_d3_ff[DIV_LAT-1][i] ? {1'b1, {(COMP_BITS-1){1'b0}}}
                                           : {1'b0, {(COMP_BITS-1){1'b1}}};
            end else if (pneg_d3_ff[DIV_LAT-1][i]) begin
               rsp_data_in.position_diff[i*COMP_BITS +: COMP_BITS] =
                  -p_quo[i][COMP_BITS-1:0];
            end else begin
               rsp_data_in.position_diff[i*COMP_BITS +: COMP_BITS] =
                  p_quo[i][COMP_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Every accepted request is followed by a result at the pipeline latency.
   `RDT_ASSERT_AFTER(a_latency, accept, PIPE_LAT, rsp_valid,
                     "result missing at the fixed pipeline latency")
   // A degenerate result carries zero distance and position.
   `RDT_ASSERT_NOW(a_degen_zero, rsp_valid && rsp_data.degenerate,
                   rsp_data.distance_diff == '0 && rsp_data.position_diff == '0,
                   "degenerate result with non-zero fields")
   // A zero radius in sphere mode always ends degenerate.
   `RDT_ASSERT_AFTER(a_zero_radius, accept && mode_ff && req_data.sphere_radius == '0,
                     PIPE_LAT, rsp_data.degenerate,
                     "zero radius in sphere mode not flagged")

endmodule

@@ tb/sv/ray_differential_transfer_top_tb.sv @@
// Self-checking testbench for ray_differential_transfer_top.
// Depends on rdt_pkg; checks every result against an exact integer predictor.
module ray_differential_transfer_top_tb;
   import rdt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [255:0] wide_type;

   localparam int WATCHDOG_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   rdt_req_type req_data = '0;
   logic        rsp_valid;
   rdt_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0;

   rdt_req_type pending_rays[$];
   rdt_rsp_type expected_transfers[$];
   logic        sphere_mode = 1'b0;
   int          mismatches = 0;
   int          rays_sent = 0;
   int          transfers_seen = 0;
   int          degenerate_seen = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          stall_cycles = 0;

   ray_differential_transfer_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Clamp an exact value into a signed range.
   function automatic wide_type clamp(wide_type v, wide_type lo, wide_type hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Exact transfer of one ray's differentials in the given mode.
   function automatic rdt_rsp_type transfer_ray(rdt_req_type r, logic sph);
      rdt_rsp_type res;
      comp_type    c;
      wide_type    tt, pv, dv, cv, nvec, dpv, ddv, m;
      wide_type    wv[3], nn[3], ev[3];
      wide_type    den, num, q, cmax, cmin;
      res = '0;
      den = 0;
      num = 0;
      tt = wide_type'(r.hit_distance);
      for (int i = 0; i < 3; i++) begin
         c = r.ray_origin[i*COMP_BITS +: COMP_BITS];     pv = wide_type'(c);
         c = r.ray_direction[i*COMP_BITS +: COMP_BITS];  dv = wide_type'(c);
         c = r.sphere_center[i*COMP_BITS +: COMP_BITS];  cv = wide_type'(c);
         c = r.surface_normal[i*COMP_BITS +: COMP_BITS]; nvec = wide_type'(c);
         c = r.origin_diff[i*COMP_BITS +: COMP_BITS];    dpv = wide_type'(c);
         c = r.direction_diff[i*COMP_BITS +: COMP_BITS]; ddv = wide_type'(c);
         wv[i] = dpv * 65536 + tt * ddv;
         if (sph) begin
            // Sphere normal rounded half up to the component fraction.
            m = pv * 65536 + dv * tt - cv * 65536 + 32768;
            nn[i] = m >>> 16;
            ev[i] = dv + ddv;
         end else begin
            nn[i] = nvec;
            ev[i] = dv;
         end
         den += ev[i] * nn[i];
         num += wv[i] * nn[i];
      end
      if (den == 0 || (sph && r.sphere_radius == '0)) begin
         res.degenerate = 1'b1;
         return res;
      end
      q = num / den;
      if (!sph) q = -q;
      res.distance_diff = DT_W'(clamp(q, -(wide_type'(1) <<< 31),
                                      (wide_type'(1) <<< 31) - 1));
      cmax = (wide_type'(1) <<< (COMP_BITS - 1)) - 1;
      cmin = -cmax - 1;
      for (int i = 0; i < 3; i++) begin
         q = (wv[i] * den - num * ev[i]) / (den * 65536);
         q = clamp(q, cmin, cmax);
         res.position_diff[i*COMP_BITS +: COMP_BITS] = q[COMP_BITS-1:0];
      end
      return res;
   endfunction

   // Random component weighted toward the extremes and small values.
   function automatic logic [COMP_BITS-1:0] pick_comp();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return {1'b0, {(COMP_BITS-1){1'b1}}};
         2: return {1'b1, {(COMP_BITS-1){1'b0}}};
         3, 4: return COMP_BITS'($urandom_range(0, 8192)) - COMP_BITS'(4096);
         default: return COMP_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [VEC_W-1:0] pick_vec();
      return {pick_comp(), pick_comp(), pick_comp()};
   endfunction

   function automatic logic [T_W-1:0] pick_scalar();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2, 3: return T_W'($urandom_range(0, 1 << 20));
         default: return T_W'($urandom);
      endcase
   endfunction

   function automatic rdt_req_type random_ray();
      rdt_req_type r;
      r.ray_origin     = pick_vec();
      r.ray_direction  = pick_vec();
      r.hit_distance   = pick_scalar();
      r.sphere_center  = pick_vec();
      r.sphere_radius  = ($urandom_range(0, 15) == 0) ? '0 : pick_scalar();
      r.surface_normal = pick_vec();
      r.origin_diff    = pick_vec();
      r.direction_diff = pick_vec();
      return r;
   endfunction

   // Write the transfer mode through the register channel.
   task automatic write_mode(logic value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sphere_mode = value;
      csr_valid <= 1'b0;
   endtask

   // Wait until every queued request has been sent and answered.
   task automatic drain();
      while (pending_rays.size() != 0 || start || expected_transfers.size() != 0)
         @(posedge clock);
   endtask

   task automatic directed_rays();
      rdt_req_type r;
      r = '0;                          pending_rays.push_back(r);
      r = '1;                          pending_rays.push_back(r);
      r = {$bits(rdt_req_type){1'b1}} >> 1; pending_rays.push_back(r);
      for (int k = 0; k < 4; k++) begin
         r = random_ray();
         // Zero direction gives a zero plane divisor.
         if (k == 0) r.ray_direction = '0;
         // Zero radius is degenerate in sphere mode.
         if (k == 1) r.sphere_radius = '0;
         // Hit point on the centre makes the sphere normal vanish.
         if (k == 2) begin
            r.sphere_center = r.ray_origin;
            r.hit_distance = '0;
         end
         if (k == 3) begin
            r.hit_distance = '1;
            r.direction_diff = {3{1'b0, {(COMP_BITS-1){1'b1}}}};
         end
         pending_rays.push_back(r);
      end
      for (int k = 0; k < 5; k++) pending_rays.push_back(random_ray());
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            expected_transfers.push_back(transfer_ray(req_data, sphere_mode));
            rays_sent++;
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_rays.size() != 0) begin
            req_data <= pending_rays.pop_front();
            start <= 1'b1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Result monitor: compare against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         transfers_seen++;
         if (expected_transfers.size() == 0) begin
            $error("unexpected result %h", rsp_data);
            mismatches++;
         end else begin
            rdt_rsp_type exp_rsp;
            exp_rsp = expected_transfers.pop_front();
            if (exp_rsp.degenerate) degenerate_seen++;
            if (rsp_data.distance_diff !== exp_rsp.distance_diff) begin
               $error("distance_diff expected %h actual %h",
                      exp_rsp.distance_diff, rsp_data.distance_diff);
               mismatches++;
            end
            if (rsp_data.position_diff !== exp_rsp.position_diff) begin
               $error("position_diff expected %h actual %h",
                      exp_rsp.position_diff, rsp_data.position_diff);
               mismatches++;
            end
            if (rsp_data.degenerate !== exp_rsp.degenerate) begin
               $error("degenerate expected %b actual %b",
                      exp_rsp.degenerate, rsp_data.degenerate);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: stop if work is outstanding but nothing moves.
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid || (pending_rays.size() == 0 && !start
             && expected_transfers.size() == 0))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles > WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Sequencing of reset, mode settings and stimulus phases.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 6; phase++) begin
         write_mode(phase[0]);
         if (phase < 2) directed_rays();
         else
            for (int k = 0; k < (phase < 4 ? 300 : 150); k++)
               pending_rays.push_back(random_ray());
         drain();
      end
      repeat (PIPE_LAT + 10) @(posedge clock);
      $display("Sent %0d rays over both transfer modes; %0d results checked, %0d degenerate.",
               rays_sent, transfers_seen, degenerate_seen);
      if (mismatches == 0 && expected_transfers.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ ray_differential_transfer_top.f @@
+incdir+rtl
rtl/rdt_pkg.sv
rtl/rdt_mul.sv
rtl/rdt_div.sv
rtl/ray_differential_transfer_top.sv
tb/sv/ray_differential_transfer_top_tb.sv
